/* rtl/core/wcm_pkg.sv */
// ----------------------------------------------------------------------------
// wcm_pkg: shared types and constants of the windowed contrast monitor
// Beat payloads, command characters, register indexes and code values.
// ----------------------------------------------------------------------------
package wcm_pkg;

  // Field widths fixed by the beat formats
  localparam int FIELD_W   = 23;
  localparam int CMD_W     = 8;
  localparam int WIN_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 2'd2;

  // Register reset values
  localparam logic [WIN_W-1:0]   WINDOW_RST = 10'd50;
  localparam logic [FIELD_W-1:0] WHITE_RST  = 23'd500;
  localparam logic [FIELD_W-1:0] FLOOR_RST  = 23'd1;

  // Input kinds
  localparam logic KIND_CMD    = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Result kinds
  localparam logic [1:0] OUT_ECHO   = 2'd0;
  localparam logic [1:0] OUT_REPORT = 2'd1;
  localparam logic [1:0] OUT_BADCMD = 2'd2;

  // Report status codes
  localparam logic [1:0] STAT_NORMAL = 2'd0;
  localparam logic [1:0] STAT_FLOOR  = 2'd1;
  localparam logic [1:0] STAT_WHITE  = 2'd2;

  // Command characters, both cases
  localparam logic [CMD_W-1:0] CH_A_UP = 8'h41;
  localparam logic [CMD_W-1:0] CH_A_LO = 8'h61;
  localparam logic [CMD_W-1:0] CH_C_UP = 8'h43;
  localparam logic [CMD_W-1:0] CH_C_LO = 8'h63;
  localparam logic [CMD_W-1:0] CH_S_UP = 8'h53;
  localparam logic [CMD_W-1:0] CH_S_LO = 8'h73;
  localparam logic [CMD_W-1:0] CH_B_UP = 8'h42;
  localparam logic [CMD_W-1:0] CH_B_LO = 8'h62;
  localparam logic [CMD_W-1:0] CH_R_UP = 8'h52;
  localparam logic [CMD_W-1:0] CH_R_LO = 8'h72;
  localparam logic [CMD_W-1:0] CH_V_UP = 8'h56;
  localparam logic [CMD_W-1:0] CH_V_LO = 8'h76;
  localparam logic [CMD_W-1:0] CH_CR   = 8'h0D;
  localparam logic [CMD_W-1:0] CH_LF   = 8'h0A;

  // Run modes
  typedef enum logic [3:0] {
    MODE_STANDBY = 4'b0001,
    MODE_CONT    = 4'b0010,
    MODE_VERIFY  = 4'b0100,
    MODE_AUTO    = 4'b1000
  } run_mode_t;

  // Control sequencer
  typedef enum logic [1:0] {
    ST_READY  = 2'b01,
    ST_DIVIDE = 2'b10
  } ctl_state_t;

  // Input beat
  typedef struct packed {
    logic               kind;
    logic [CMD_W-1:0]   cmd_byte;
    logic [FIELD_W-1:0] lux_sample;
    logic               sample_ok;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [1:0]         out_kind;
    logic [FIELD_W-1:0] level_out;
    logic [FIELD_W-1:0] min_out;
    logic [FIELD_W-1:0] contrast_ratio;
    logic [1:0]         report_status;
    logic [CMD_W-1:0]   bad_command;
  } out_beat_t;

  // Divider status toward the controller
  typedef struct packed {
    logic busy;
    logic idle;
  } div_stat_t;

endpackage

/* rtl/core/wcm_div.sv */
// ----------------------------------------------------------------------------
// wcm_div: bit-serial rounded divider
// Computes (2*num + den) / (2*den), one quotient bit per cycle by restoring
// division, and saturates the quotient to the result field width.
// ----------------------------------------------------------------------------
module wcm_div
  import wcm_pkg::*;
#(
  parameter int EXT_W = 23
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  logic [EXT_W-1:0]   num_i,
  input  logic [EXT_W-1:0]   den_i,
  output div_stat_t          stat_o,
  output logic [FIELD_W-1:0] quot_o
);

  localparam int DIVW  = EXT_W + 2;
  localparam int REMW  = EXT_W + 2;
  localparam int CNT_W = $clog2(DIVW + 1);

  logic [DIVW-1:0]  q_r, q_nxt;
  logic [REMW-1:0]  rem_r, rem_nxt;
  logic [EXT_W:0]   dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;

  logic [REMW-1:0]  rem_sh;
  logic [REMW-1:0]  dsr_ext;
  logic             ge;

  // One restoring step: shift in the next dividend bit, try the subtract
  assign rem_sh  = {rem_r[REMW-2:0], q_r[DIVW-1]};
  assign dsr_ext = REMW'(dsr_r);
  assign ge      = (rem_sh >= dsr_ext);

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start_i) begin
      q_nxt    = (DIVW'(num_i) << 1) + DIVW'(den_i);
      rem_nxt  = '0;
      dsr_nxt  = (EXT_W+1)'(den_i) << 1;
      cnt_nxt  = CNT_W'(DIVW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DIVW-2:0], ge};
      rem_nxt = ge ? (rem_sh - dsr_ext) : rem_sh;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat_o.busy = busy_r;
  assign stat_o.idle = !busy_r;
  assign quot_o = (q_r > DIVW'(FIELD_MAX)) ? FIELD_MAX : q_r[FIELD_W-1:0];

endmodule

/* rtl/core/windowed_contrast_monitor_top.sv */
// ----------------------------------------------------------------------------
// windowed_contrast_monitor_top: light-level contrast monitor
// Command decoding, sample echo, windowed max/min statistics and reports.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per command byte or light sample (valid/stall).
//   out_* : zero or one result beat per input beat (valid/stall), held in an
//           output register; the next input beat is taken no earlier than
//           the edge at which the held result is taken.
//   cfg_* : register writes (window length, white threshold, black floor),
//           always ready; write only while the block is idle.
// Result timing:
//   Commands, echoes and white-too-low reports are registered: a result
//   appears the cycle after the beat is accepted, one beat per cycle while
//   out_stall is low and no divide runs. A report with a ratio starts the
//   bit-serial divider when the beat is accepted; in_stall stays high while
//   it runs, and the report is registered when the divider is idle and the
//   output is free.
// Reset: mode idle, statistics cleared, registers at their reset values,
//   no result pending.
// Stall: while out_stall holds a result, no input beat is taken (in_stall
//   high); the held result stays unchanged.
// ----------------------------------------------------------------------------
module windowed_contrast_monitor_top
  import wcm_pkg::*;
#(
  parameter int LEVEL_BITS = 23,
  parameter int COUNT_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data
);

  localparam int EXT_W = (LEVEL_BITS > FIELD_W) ? LEVEL_BITS : FIELD_W;
  localparam int CW_W  = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;
  localparam logic [CW_W-1:0] CNT_MAX = CW_W'({COUNT_BITS{1'b1}});

  // Configuration registers
  logic [WIN_W-1:0]   window_r;
  logic [FIELD_W-1:0] white_r;
  logic [FIELD_W-1:0] floor_r;

  // State
  run_mode_t            mode_r, mode_nxt;
  ctl_state_t           st_r, st_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [LEVEL_BITS-1:0] max_r, max_nxt;
  logic [LEVEL_BITS-1:0] min_r, min_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_r, out_nxt;

  // Report fields held during the divide
  logic [FIELD_W-1:0] rep_max_r, rep_max_nxt;
  logic [FIELD_W-1:0] rep_min_r, rep_min_nxt;
  logic [1:0]         rep_stat_r, rep_stat_nxt;

  logic                  out_free;
  logic                  accept;
  logic [LEVEL_BITS-1:0] lux_l;
  logic [LEVEL_BITS-1:0] upd_max, upd_min;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [CW_W-1:0]       win_eff;
  logic                  win_full;
  logic [EXT_W-1:0]      max_ext, min_ext, floor_ext, white_ext, floor_den;
  logic                  floor_hit;
  logic                  div_start;
  logic [EXT_W-1:0]      div_den;
  div_stat_t             div_stat;
  logic [FIELD_W-1:0]    div_quot;

  // Handshakes
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (st_r != ST_READY) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Sample statistics
  assign lux_l    = LEVEL_BITS'(in_data.lux_sample);
  assign upd_max  = (lux_l > max_r) ? lux_l : max_r;
  assign upd_min  = (lux_l < min_r) ? lux_l : min_r;
  assign cnt_inc  = cnt_r + COUNT_BITS'(1);

  // Effective window: zero acts as one, clipped to the counter range
  always_comb begin
    win_eff = CW_W'(window_r);
    if (window_r == '0) begin
      win_eff = CW_W'(1);
    end
    if (win_eff > CNT_MAX) begin
      win_eff = CNT_MAX;
    end
  end
  assign win_full = (CW_W'(cnt_inc) >= win_eff);

  // Report classification on the updated statistics
  assign max_ext   = EXT_W'(upd_max);
  assign min_ext   = EXT_W'(upd_min);
  assign floor_ext = EXT_W'(floor_r);
  assign white_ext = EXT_W'(white_r);
  assign floor_den = (floor_r == '0) ? EXT_W'(1) : floor_ext;
  assign floor_hit = (min_ext <= floor_ext);
  assign div_den   = floor_hit ? floor_den : min_ext;

  // Next-state logic
  always_comb begin
    mode_nxt      = mode_r;
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    rep_max_nxt   = rep_max_r;
    rep_min_nxt   = rep_min_r;
    rep_stat_nxt  = rep_stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    div_start     = 1'b0;

    case (st_r)
      ST_READY: begin
        if (accept) begin
          out_nxt = '0;
          if (in_data.kind == KIND_CMD) begin
            case (in_data.cmd_byte)
              CH_A_UP, CH_A_LO: begin
                mode_nxt = MODE_AUTO;
                cnt_nxt  = '0;
                max_nxt  = '0;
                min_nxt  = '1;
              end
              CH_C_UP, CH_C_LO: mode_nxt = MODE_CONT;
              CH_S_UP, CH_S_LO, CH_B_UP, CH_B_LO, CH_R_UP, CH_R_LO: begin
                mode_nxt = MODE_STANDBY;
              end
              CH_V_UP, CH_V_LO: mode_nxt = MODE_VERIFY;
              CH_CR, CH_LF: begin
              end
              default: begin
                out_valid_nxt       = 1'b1;
                out_nxt.out_kind    = OUT_BADCMD;
                out_nxt.bad_command = in_data.cmd_byte;
              end
            endcase
          end else if (in_data.sample_ok) begin
            if (mode_r == MODE_CONT) begin
              out_valid_nxt     = 1'b1;
              out_nxt.out_kind  = OUT_ECHO;
              out_nxt.level_out = FIELD_W'(EXT_W'(lux_l));
            end else if (mode_r == MODE_AUTO) begin
              if (win_full) begin
                // Window full: report and clear the statistics
                cnt_nxt     = '0;
                max_nxt     = '0;
                min_nxt     = '1;
                rep_max_nxt = FIELD_W'(max_ext);
                rep_min_nxt = FIELD_W'(min_ext);
                if (floor_hit) begin
                  rep_stat_nxt = STAT_FLOOR;
                  div_start    = 1'b1;
                  st_nxt       = ST_DIVIDE;
                end else if (max_ext < white_ext) begin
                  out_valid_nxt         = 1'b1;
                  out_nxt.out_kind      = OUT_REPORT;
                  out_nxt.level_out     = FIELD_W'(max_ext);
                  out_nxt.min_out       = FIELD_W'(min_ext);
                  out_nxt.report_status = STAT_WHITE;
                end else begin
                  rep_stat_nxt = STAT_NORMAL;
                  div_start    = 1'b1;
                  st_nxt       = ST_DIVIDE;
                end
              end else begin
                cnt_nxt = cnt_inc;
                max_nxt = upd_max;
                min_nxt = upd_min;
              end
            end
          end
        end
      end
      ST_DIVIDE: begin
        // Emit the report once the divider has settled and the output is free
        if (div_stat.idle && out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt                = '0;
          out_nxt.out_kind       = OUT_REPORT;
          out_nxt.level_out      = rep_max_r;
          out_nxt.min_out        = rep_min_r;
          out_nxt.contrast_ratio = div_quot;
          out_nxt.report_status  = rep_stat_r;
          st_nxt                 = ST_READY;
        end
      end
      default: st_nxt = ST_READY;
    endcase
  end

  // Control state and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STANDBY;
      st_r        <= ST_READY;
      cnt_r       <= '0;
      max_r       <= '0;
      min_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    rep_max_r  <= rep_max_nxt;
    rep_min_r  <= rep_min_nxt;
    rep_stat_r <= rep_stat_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      white_r  <= WHITE_RST;
      floor_r  <= FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW: window_r <= cfg_data[WIN_W-1:0];
        REG_WHITE:  white_r  <= cfg_data;
        REG_FLOOR:  floor_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Bit-serial ratio divider
  wcm_div #(
    .EXT_W (EXT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (max_ext),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* sim/wcm_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wcm_checker: result checker for the windowed contrast monitor
// Watches the input, result and register write channels. It keeps its own
// copy of mode, window statistics and registers, works out the result each
// accepted input beat owes, and compares result beats field by field in order.
// ----------------------------------------------------------------------------
module wcm_checker
  import wcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_beat_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_beat_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  output int                   fail_count,
  output int                   owed_count
);

  // Register copies
  logic [WIN_W-1:0]   win_len;
  logic [FIELD_W-1:0] white_lvl;
  logic [FIELD_W-1:0] floor_lvl;

  // Mode and window statistics
  run_mode_t          mode;
  logic [WIN_W-1:0]   n_seen;
  logic [FIELD_W-1:0] hi_lvl;
  logic [FIELD_W-1:0] lo_lvl;

  // Result beats owed by accepted inputs, oldest first
  out_beat_t owed_results[$];

  // Rounded quotient, halves up, saturated to the field width
  function automatic logic [FIELD_W-1:0] round_div(logic [FIELD_W-1:0] num,
                                                   logic [FIELD_W-1:0] den);
    logic [63:0] d;
    logic [63:0] q;
    d = (den == '0) ? 64'd1 : 64'(den);
    q = (2 * 64'(num) + d) / (2 * d);
    return (q > 64'(FIELD_MAX)) ? FIELD_MAX : q[FIELD_W-1:0];
  endfunction

  task automatic clear_window();
    n_seen = '0;
    hi_lvl = '0;
    lo_lvl = FIELD_MAX;
  endtask

  // Apply one input beat; queue the result it causes, if any
  task automatic monitor_step(in_beat_t b);
    out_beat_t        r;
    logic [WIN_W-1:0] span;
    r = '0;
    if (b.kind == KIND_CMD) begin
      case (b.cmd_byte)
        CH_A_UP, CH_A_LO: begin
          mode = MODE_AUTO;
          clear_window();
        end
        CH_C_UP, CH_C_LO: mode = MODE_CONT;
        CH_S_UP, CH_S_LO, CH_B_UP, CH_B_LO, CH_R_UP, CH_R_LO: mode = MODE_STANDBY;
        CH_V_UP, CH_V_LO: mode = MODE_VERIFY;
        CH_CR, CH_LF: ;
        default: begin
          r.out_kind    = OUT_BADCMD;
          r.bad_command = b.cmd_byte;
          owed_results.push_back(r);
        end
      endcase
    end else if (b.sample_ok) begin
      if (mode == MODE_CONT) begin
        r.out_kind  = OUT_ECHO;
        r.level_out = b.lux_sample;
        owed_results.push_back(r);
      end else if (mode == MODE_AUTO) begin
        // a zero window behaves as one sample
        span = (win_len == '0) ? WIN_W'(1) : win_len;
        if (b.lux_sample > hi_lvl) hi_lvl = b.lux_sample;
        if (b.lux_sample < lo_lvl) lo_lvl = b.lux_sample;
        n_seen = n_seen + 1'b1;
        if (n_seen >= span) begin
          r.out_kind  = OUT_REPORT;
          r.level_out = hi_lvl;
          r.min_out   = lo_lvl;
          // floor test wins over the white test
          if (lo_lvl <= floor_lvl) begin
            r.contrast_ratio = round_div(hi_lvl, floor_lvl);
            r.report_status  = STAT_FLOOR;
          end else if (hi_lvl < white_lvl) begin
            r.report_status  = STAT_WHITE;
          end else begin
            r.contrast_ratio = round_div(hi_lvl, lo_lvl);
            r.report_status  = STAT_NORMAL;
          end
          owed_results.push_back(r);
          clear_window();
        end
      end
    end
  endtask

  function automatic bit field_bad(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Result beats are retired before the input beat of the same edge is applied
  always @(posedge clk) begin : watch
    out_beat_t want;
    bit        bad;
    if (!rst_n) begin
      win_len    = WINDOW_RST;
      white_lvl  = WHITE_RST;
      floor_lvl  = FLOOR_RST;
      mode       = MODE_STANDBY;
      fail_count = 0;
      clear_window();
      owed_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("result beat with nothing owed: out_kind %0d", out_data.out_kind);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          bad  = 1'b0;
          bad |= field_bad("out_kind", want.out_kind, out_data.out_kind);
          bad |= field_bad("level_out", want.level_out, out_data.level_out);
          bad |= field_bad("min_out", want.min_out, out_data.min_out);
          bad |= field_bad("contrast_ratio", want.contrast_ratio,
                           out_data.contrast_ratio);
          bad |= field_bad("report_status", want.report_status, out_data.report_status);
          bad |= field_bad("bad_command", want.bad_command, out_data.bad_command);
          if (bad) fail_count++;
        end
      end
      if (in_valid && !in_stall) monitor_step(in_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW: win_len   = cfg_data[WIN_W-1:0];
          REG_WHITE:  white_lvl = cfg_data;
          REG_FLOOR:  floor_lvl = cfg_data;
          default: ;
        endcase
      end
    end
    owed_count <= owed_results.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for windowed_contrast_monitor_top
// Drives command and sample beats with random gaps and result stalls through
// several register settings: a directed pass over modes, report statuses and
// command bytes, then random mixes and one long window. Checking is
// done by wcm_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import wcm_pkg::*;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_beat_t             in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0]   cfg_data  = '0;
  logic                 in_stall;
  logic                 out_valid;
  out_beat_t            out_data;
  logic                 cfg_ready;
  int                   fail_count;
  int                   owed_count;

  // no input gaps while set; result stalls stop once the current run ends
  bit calm = 1'b0;

  logic [CMD_W-1:0] cmd_pool [14] = '{CH_A_UP, CH_A_LO, CH_C_UP, CH_C_LO, CH_S_UP,
                                      CH_S_LO, CH_B_UP, CH_B_LO, CH_R_UP, CH_R_LO,
                                      CH_V_UP, CH_V_LO, CH_CR, CH_LF};

  always #5 clk = ~clk;

  windowed_contrast_monitor_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wcm_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .owed_count (owed_count)
  );

  // Result-side stalls: runs of random length, mostly short
  int unsigned hold_left = 0;
  always @(posedge clk) begin : stall_gen
    int unsigned r;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall <= 1'b0;
        hold_left <= $urandom_range(0, 6);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        hold_left <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        hold_left <= $urandom_range(15, 60);
      end
    end
  end

  function automatic logic [FIELD_W-1:0] pick_lux();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return FIELD_W'($urandom_range(0, 3));
    if (r < 35) return FIELD_W'($urandom_range(0, 2000));
    if (r < 55) return FIELD_W'($urandom_range(0, 100000));
    if (r < 90) return FIELD_W'($urandom);
    if (r < 95) return FIELD_MAX;
    return FIELD_MAX - FIELD_W'($urandom_range(0, 3000));
  endfunction

  // Unused fields of a beat carry random bits
  function automatic in_beat_t cmd_beat(logic [CMD_W-1:0] c);
    in_beat_t b;
    b.kind       = KIND_CMD;
    b.cmd_byte   = c;
    b.lux_sample = FIELD_W'($urandom);
    b.sample_ok  = 1'($urandom);
    return b;
  endfunction

  function automatic in_beat_t sample_beat(logic [FIELD_W-1:0] lux, logic ok);
    in_beat_t b;
    b.kind       = KIND_SAMPLE;
    b.cmd_byte   = CMD_W'($urandom);
    b.lux_sample = lux;
    b.sample_ok  = ok;
    return b;
  endfunction

  function automatic in_beat_t mix_beat(int cmd_pct);
    int unsigned r;
    if ($urandom_range(0, 99) >= cmd_pct)
      return sample_beat(pick_lux(), $urandom_range(0, 9) != 0);
    r = $urandom_range(0, 99);
    if (r < 30) return cmd_beat($urandom_range(0, 1) ? CH_A_UP : CH_A_LO);
    if (r < 80) return cmd_beat(cmd_pool[$urandom_range(0, 13)]);
    return cmd_beat(CMD_W'($urandom));
  endfunction

  // One input beat, then an optional idle gap
  task automatic send(in_beat_t b);
    int unsigned r;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    r = $urandom_range(0, 99);
    if (!calm && r >= 50) begin
      in_valid <= 1'b0;
      repeat (r < 88 ? $urandom_range(1, 3) :
              r < 97 ? $urandom_range(4, 12) : $urandom_range(20, 60)) @(posedge clk);
    end
  endtask

  // Wait for every owed result, then let a divide in flight finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_count != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_regs(logic [WIN_W-1:0] win, logic [FIELD_W-1:0] white,
                            logic [FIELD_W-1:0] floor_v);
    logic [CFG_IDX_W-1:0] idx  [3];
    logic [FIELD_W-1:0]   vals [3];
    idx  = '{REG_WINDOW, REG_WHITE, REG_FLOOR};
    vals = '{FIELD_W'(win), white, floor_v};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_mix(int n, int cmd_pct);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      send(mix_beat(cmd_pct));
    end
    calm = 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    in_beat_t dir_beats[$];
    int       n_ok;
    logic     ok;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: window 2, white 1000, floor 100
    write_regs(2, 1000, 100);
    dir_beats.push_back(cmd_beat(CH_C_LO));
    dir_beats.push_back(sample_beat('0, 1'b1));
    dir_beats.push_back(sample_beat(FIELD_MAX, 1'b1));
    dir_beats.push_back(sample_beat(1234, 1'b0));          // bad sensor status
    dir_beats.push_back(cmd_beat(CH_V_UP));
    dir_beats.push_back(sample_beat(77, 1'b1));            // dropped in verify
    dir_beats.push_back(cmd_beat(CH_S_UP));
    dir_beats.push_back(sample_beat(88, 1'b1));            // dropped when idle
    dir_beats.push_back(cmd_beat(CH_CR));
    dir_beats.push_back(cmd_beat(CH_LF));
    dir_beats.push_back(cmd_beat(8'hFF));
    dir_beats.push_back(cmd_beat(8'h00));
    dir_beats.push_back(cmd_beat(CH_A_UP));
    dir_beats.push_back(sample_beat(50, 1'b1));            // floor reached
    dir_beats.push_back(sample_beat(5000, 1'b1));
    dir_beats.push_back(sample_beat(300, 1'b1));           // white too low
    dir_beats.push_back(sample_beat(800, 1'b1));
    dir_beats.push_back(sample_beat(2000, 1'b1));          // ratio 2.5 rounds up
    dir_beats.push_back(sample_beat(800, 1'b1));
    dir_beats.push_back(cmd_beat(CH_A_LO));
    dir_beats.push_back(sample_beat(FIELD_MAX, 1'b1));
    dir_beats.push_back(sample_beat(101, 1'b1));
    dir_beats.push_back(cmd_beat(CH_B_LO));
    dir_beats.push_back(cmd_beat(CH_R_UP));
    dir_beats.push_back(cmd_beat(CH_S_LO));
    foreach (dir_beats[i]) send(dir_beats[i]);
    settle();

    // Reset values, longer commands-free stretches so windows can fill
    write_regs(WINDOW_RST, WHITE_RST, FLOOR_RST);
    run_mix(160, 5);
    settle();

    // Zero floor, no white threshold, single-sample window
    write_regs(1, '0, '0);
    run_mix(160, 12);
    settle();

    // Zero window, thresholds at the top of the field
    write_regs('0, FIELD_MAX, FIELD_MAX);
    run_mix(140, 12);
    settle();

    // Long window: one full window of valid samples, invalid ones mixed in
    write_regs(255, 1000, 50);
    send(cmd_beat(CH_A_UP));
    n_ok = 0;
    while (n_ok < 255) begin
      ok = ($urandom_range(0, 32) != 0);
      if (ok) n_ok++;
      send(sample_beat(pick_lux(), ok));
    end
    settle();

    write_regs(4, FIELD_W'($urandom_range(0, 5000)), FIELD_W'($urandom_range(1, 500)));
    run_mix(180, 10);
    settle();

    write_regs(7, FIELD_W'($urandom), 1);
    run_mix(180, 10);
    settle();

    @(negedge clk);
    if (fail_count == 0 && owed_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

/* windowed_contrast_monitor_top.f */
rtl/core/wcm_pkg.sv
rtl/core/wcm_div.sv
rtl/core/windowed_contrast_monitor_top.sv
sim/wcm_checker.sv
sim/tb_top.sv
